// ----- design/lkc_pkg.sv -----
// Shared types and constants for the LRU key cache.
package lkc_pkg;

	localparam int KEY_W = 64;
	localparam int CFG_W = 6;
	localparam int KIND_W = 2;
	localparam logic [CFG_W-1:0] CACHE_SIZE_RST = 6'd32;

	localparam logic [KIND_W-1:0] KIND_ADD = 2'd0;
	localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd2;

	localparam int Q_DEPTH = 2;
	localparam int Q_AW = $clog2(Q_DEPTH);
	localparam int Q_CW = $clog2(Q_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_ADD,
		OP_QUERY,
		OP_FLUSH,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t             op;
		logic [KEY_W-1:0] key;
	} cmd_t;

	typedef struct packed {
		logic             has_unload;
		logic [KEY_W-1:0] unload_key;
		logic             present;
		logic             last;
	} res_t;

endpackage

// ----- design/lkc_front.sv -----
// Request front end: accepts and classifies transactions, hands them to the queue.
module lkc_front import lkc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [KIND_W-1:0] kind,
	input  logic [KEY_W-1:0]  key,
	output logic              push,
	output cmd_t              push_cmd,
	input  logic              full
);

	logic valid_s1;
	cmd_t cmd_s1;
	op_t  op;
	logic accept;

	assign push     = valid_s1 && !full;
	assign busy     = valid_s1 && full;
	assign accept   = start && !busy;
	assign push_cmd = cmd_s1;

	always_comb begin
		unique case (kind)
			KIND_ADD:   op = OP_ADD;
			KIND_QUERY: op = OP_QUERY;
			KIND_FLUSH: op = OP_FLUSH;
			default:    op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= '{op: op, key: key};
		end
	end

endmodule

// ----- design/lkc_fifo.sv -----
// Short command queue between the front end and the execution engine.
module lkc_fifo import lkc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t pop_cmd,
	output logic empty
);

	cmd_t            slots [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_CW-1:0] cnt_q;

	assign full    = (cnt_q == Q_CW'(Q_DEPTH));
	assign empty   = (cnt_q == '0);
	assign pop_cmd = slots[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + Q_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + Q_AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + Q_CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - Q_CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ----- design/lkc_back.sv -----
// Execution engine: key memory walk for search, compaction and flush.
module lkc_back import lkc_pkg::*; #(
	parameter int CAPACITY = 32,
	localparam int AW = $clog2(CAPACITY),
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [CW-1:0] limit,
	input  logic          empty,
	output logic          pop,
	input  cmd_t          pop_cmd,
	output logic          res_vld,
	output res_t          res
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SRCH,
		S_SHIFT,
		S_FLUSH
	} state_t;

	state_t           state_q;
	cmd_t             cmd_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    ptr_q;
	logic             chk_vld_q;
	logic [AW-1:0]    chk_idx_q;
	logic [KEY_W-1:0] old_q;
	logic [KEY_W-1:0] rd_data_q;
	logic             res_vld_q;
	res_t             res_q;

	logic [KEY_W-1:0] mem [CAPACITY];

	logic             issue;
	logic             drained;
	logic             hit;
	logic             flush_last;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [KEY_W-1:0] wr_data;

	localparam res_t RES_EMPTY = '{has_unload: 1'b0, unload_key: '0, present: 1'b0, last: 1'b1};

	assign pop        = (state_q == S_IDLE) && !empty;
	assign issue      = (state_q != S_IDLE) && (ptr_q < count_q);
	assign drained    = !issue && !chk_vld_q;
	assign hit        = chk_vld_q && (rd_data_q == cmd_q.key);
	assign flush_last = (CW'(chk_idx_q) == count_q - CW'(1));
	assign res_vld    = res_vld_q;
	assign res        = res_q;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		unique case (state_q)
			S_SRCH: begin
				if (drained && cmd_q.op == OP_ADD && count_q < limit) begin
					wr_en   = 1'b1;
					wr_addr = count_q[AW-1:0];
					wr_data = cmd_q.key;
				end
			end
			S_SHIFT: begin
				if (chk_vld_q) begin
					wr_en   = 1'b1;
					wr_addr = chk_idx_q - AW'(1);
					wr_data = rd_data_q;
				end else if (!issue) begin
					wr_en   = 1'b1;
					wr_addr = AW'(count_q - CW'(1));
					wr_data = cmd_q.key;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[ptr_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cmd_q     <= '0;
			count_q   <= '0;
			ptr_q     <= '0;
			chk_vld_q <= 1'b0;
			chk_idx_q <= '0;
			old_q     <= '0;
			res_vld_q <= 1'b0;
			res_q     <= '0;
		end else begin
			res_vld_q <= 1'b0;
			if (issue) begin
				ptr_q     <= ptr_q + CW'(1);
				chk_vld_q <= 1'b1;
				chk_idx_q <= ptr_q[AW-1:0];
			end else begin
				chk_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						cmd_q <= pop_cmd;
						ptr_q <= '0;
						unique case (pop_cmd.op)
							OP_ADD, OP_QUERY: begin
								state_q <= S_SRCH;
							end
							OP_FLUSH: begin
								if (count_q == '0) begin
									res_vld_q <= 1'b1;
									res_q     <= RES_EMPTY;
								end else begin
									state_q <= S_FLUSH;
								end
							end
							OP_NOP: begin
								res_vld_q <= 1'b1;
								res_q     <= RES_EMPTY;
							end
						endcase
					end
				end
				S_SRCH: begin
					if (chk_vld_q && chk_idx_q == '0) begin
						old_q <= rd_data_q;
					end
					if (hit) begin
						res_vld_q <= 1'b1;
						if (cmd_q.op == OP_QUERY) begin
							res_q <= '{has_unload: 1'b0, unload_key: '0,
								present: 1'b1, last: 1'b1};
							state_q <= S_IDLE;
						end else begin
							res_q <= '{has_unload: 1'b1, unload_key: cmd_q.key,
								present: 1'b1, last: 1'b1};
							ptr_q     <= CW'(chk_idx_q) + CW'(1);
							chk_vld_q <= 1'b0;
							state_q   <= S_SHIFT;
						end
					end else if (drained) begin
						res_vld_q <= 1'b1;
						if (cmd_q.op == OP_QUERY) begin
							res_q   <= RES_EMPTY;
							state_q <= S_IDLE;
						end else if (count_q < limit) begin
							res_q   <= RES_EMPTY;
							count_q <= count_q + CW'(1);
							state_q <= S_IDLE;
						end else begin
							res_q <= '{has_unload: 1'b1, unload_key: old_q,
								present: 1'b0, last: 1'b1};
							ptr_q   <= CW'(1);
							state_q <= S_SHIFT;
						end
					end
				end
				S_SHIFT: begin
					if (drained) begin
						state_q <= S_IDLE;
					end
				end
				S_FLUSH: begin
					if (chk_vld_q) begin
						res_vld_q <= 1'b1;
						res_q <= '{has_unload: 1'b1, unload_key: rd_data_q,
							present: 1'b0, last: flush_last};
						if (flush_last) begin
							count_q <= '0;
							state_q <= S_IDLE;
						end
					end
				end
			endcase
		end
	end

endmodule

// ----- design/lru_key_cache_with_eviction.sv -----
// Top level of the LRU key cache with eviction.
// Holds up to cache_size 64-bit keys, oldest first, in a single-port-read key memory that
// the engine walks one entry per clock. A transaction is taken when start is high and busy
// is low; a two-entry queue sits between the front end and the engine, so a few requests
// can be taken while an earlier one is still running. Every result appears for exactly one
// cycle with done high and cannot be held off. An add or query walks the held keys in
// order and stops at a match; an add that moves or evicts a key then compacts them. A
// flush streams one result per held key on consecutive cycles. A cache_size of 0 acts
// as 1, one above CAPACITY as CAPACITY. The key memory needs no clearing after reset.
module lru_key_cache_with_eviction import lkc_pkg::*; #(
	parameter int CAPACITY = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [KIND_W-1:0] kind,
	input  logic [KEY_W-1:0]  key,
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_wdata,
	output logic              done,
	output logic              has_unload,
	output logic [KEY_W-1:0]  unload_key,
	output logic              present,
	output logic              last
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CFG_W-1:0] cache_size_q;
	logic [CW-1:0]    limit;
	logic             push;
	cmd_t             push_cmd;
	logic             full;
	logic             pop;
	cmd_t             pop_cmd;
	logic             empty;
	logic             res_vld;
	res_t             res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cache_size_q <= CACHE_SIZE_RST;
		end else if (cfg_we) begin
			cache_size_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (cache_size_q == '0) begin
			limit = CW'(1);
		end else if (int'(cache_size_q) > CAPACITY) begin
			limit = CW'(CAPACITY);
		end else begin
			limit = CW'(cache_size_q);
		end
	end

	lkc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.kind     (kind),
		.key      (key),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full)
	);

	lkc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.empty    (empty)
	);

	lkc_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.limit   (limit),
		.empty   (empty),
		.pop     (pop),
		.pop_cmd (pop_cmd),
		.res_vld (res_vld),
		.res     (res)
	);

	assign done       = res_vld;
	assign has_unload = res.has_unload;
	assign unload_key = res.unload_key;
	assign present    = res.present;
	assign last       = res.last;

endmodule

// ----- design/lkc_checker.sv -----
// Port-level checks for the LRU key cache, bound to the top level.
module lkc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        done,
	input logic        has_unload,
	input logic [63:0] unload_key,
	input logic        present,
	input logic        last
);

	a_idle_key_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !has_unload |-> unload_key == '0)
		else $error("unload_key nonzero on a result without unload");

	a_burst_cont: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |=> done)
		else $error("flush burst broken before its last result");

	a_burst_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |-> has_unload && !present)
		else $error("non-final result is not a flush unload");

endmodule

bind lru_key_cache_with_eviction lkc_checker u_chk (.*);

// ----- tb/tb_lru_key_cache_with_eviction.sv -----
// Self-checking testbench for the LRU key cache: directed table, random phases, predictor.
`timescale 1ns / 100ps

module tb_lru_key_cache_with_eviction;
	import lkc_pkg::*;

	localparam int CAP = 32;
	localparam int SETTLE = 2 * CAP + 16;
	localparam int POOL_N = 20;
	localparam int N_DIR = 28;
	localparam int N_PHASE = 6;
	localparam logic [KEY_W-1:0] KEY_ONES = {KEY_W{1'b1}};

	localparam res_t RES_PLAIN = '{1'b0, 64'd0, 1'b0, 1'b1};
	localparam res_t RES_FOUND = '{1'b0, 64'd0, 1'b1, 1'b1};
	localparam res_t RES_MOVE_ZERO = '{1'b1, 64'd0, 1'b1, 1'b1};

	typedef struct packed {
		op_t              op;
		logic [KEY_W-1:0] key;
		logic             cfg;
		logic [CFG_W-1:0] size;
		logic             chk;
		res_t             want;
	} dir_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [KIND_W-1:0] kind;
	logic [KEY_W-1:0]  key;
	logic              cfg_we;
	logic [CFG_W-1:0]  cfg_wdata;
	logic              done;
	logic              has_unload;
	logic [KEY_W-1:0]  unload_key;
	logic              present;
	logic              last;

	logic [KEY_W-1:0] held_keys [CAP];
	int               held_n;
	logic [CFG_W-1:0] size_reg;
	res_t             next_res [$];
	res_t             pending_res [$];
	logic [KEY_W-1:0] key_pool [POOL_N];
	int               err_cnt = 0;

	int               idle_pct [N_PHASE] = '{0, 72, 0, 6, 72, 0};
	int               flush_pct [N_PHASE] = '{8, 8, 2, 8, 6, 6};
	int               phase_items [N_PHASE] = '{30, 30, 40, 30, 30, 30};
	logic [CFG_W-1:0] phase_size [N_PHASE] = '{6'd2, 6'd1, 6'd63, 6'd0, 6'd5, 6'd32};

	dir_row_t dir_rows [N_DIR] = '{
		'{OP_FLUSH, 64'd0,                  1'b0, 6'd0,  1'b1, RES_PLAIN},
		'{OP_QUERY, 64'd0,                  1'b0, 6'd0,  1'b1, RES_PLAIN},
		'{OP_ADD,   64'd0,                  1'b0, 6'd0,  1'b1, RES_PLAIN},
		'{OP_ADD,   KEY_ONES,               1'b0, 6'd0,  1'b1, RES_PLAIN},
		'{OP_QUERY, KEY_ONES,               1'b0, 6'd0,  1'b1, RES_FOUND},
		'{OP_ADD,   64'd0,                  1'b0, 6'd0,  1'b1, RES_MOVE_ZERO},
		'{OP_NOP,   64'hA5A5_A5A5_A5A5_A5A5, 1'b0, 6'd0,  1'b1, RES_PLAIN},
		'{OP_ADD,   64'h8000_0000_0000_0001, 1'b0, 6'd0,  1'b0, RES_PLAIN},
		'{OP_QUERY, 64'h5555_5555_5555_5555, 1'b0, 6'd0,  1'b0, RES_PLAIN},
		'{OP_FLUSH, 64'd0,                  1'b0, 6'd0,  1'b0, RES_PLAIN},
		'{OP_FLUSH, 64'd0,                  1'b0, 6'd0,  1'b1, RES_PLAIN},
		'{OP_NOP,   64'd0,                  1'b1, 6'd1,  1'b0, RES_PLAIN},
		'{OP_ADD,   64'h1111,               1'b0, 6'd0,  1'b0, RES_PLAIN},
		'{OP_ADD,   64'h2222,               1'b0, 6'd0,  1'b0, RES_PLAIN},
		'{OP_QUERY, 64'h1111,               1'b0, 6'd0,  1'b0, RES_PLAIN},
		'{OP_NOP,   64'd0,                  1'b1, 6'd0,  1'b0, RES_PLAIN},
		'{OP_ADD,   64'h3333,               1'b0, 6'd0,  1'b0, RES_PLAIN},
		'{OP_NOP,   64'd0,                  1'b1, 6'd3,  1'b0, RES_PLAIN},
		'{OP_ADD,   64'h4444,               1'b0, 6'd0,  1'b0, RES_PLAIN},
		'{OP_ADD,   64'h5555,               1'b0, 6'd0,  1'b0, RES_PLAIN},
		'{OP_ADD,   64'h4444,               1'b0, 6'd0,  1'b0, RES_PLAIN},
		'{OP_NOP,   64'd0,                  1'b1, 6'd1,  1'b0, RES_PLAIN},
		'{OP_ADD,   64'h6666,               1'b0, 6'd0,  1'b0, RES_PLAIN},
		'{OP_ADD,   64'h7777,               1'b0, 6'd0,  1'b0, RES_PLAIN},
		'{OP_FLUSH, 64'd0,                  1'b0, 6'd0,  1'b0, RES_PLAIN},
		'{OP_NOP,   64'd0,                  1'b1, 6'd63, 1'b0, RES_PLAIN},
		'{OP_ADD,   64'hFFFF_FFFF_0000_0000, 1'b0, 6'd0,  1'b0, RES_PLAIN},
		'{OP_FLUSH, 64'd0,                  1'b0, 6'd0,  1'b0, RES_PLAIN}
	};

	lru_key_cache_with_eviction #(
		.CAPACITY(CAP)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.kind      (kind),
		.key       (key),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.has_unload(has_unload),
		.unload_key(unload_key),
		.present   (present),
		.last      (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void drop_entry(int pos);
		for (int i = pos; i + 1 < held_n; i++)
			held_keys[i] = held_keys[i + 1];
		held_n--;
	endfunction

	function automatic void push_key(logic [KEY_W-1:0] k);
		if (held_n < CAP) begin
			held_keys[held_n] = k;
			held_n++;
		end
	endfunction

	function automatic void queue_res(res_t r);
		next_res.insert(next_res.size(), r);
	endfunction

	function automatic void predict_item(op_t op, logic [KEY_W-1:0] k);
		int               pos;
		int               lim;
		logic [KEY_W-1:0] oldest;
		next_res.delete();
		pos = -1;
		for (int i = 0; i < held_n; i++)
			if (pos < 0 && held_keys[i] == k)
				pos = i;
		lim = (size_reg == 0) ? 1 : ((int'(size_reg) > CAP) ? CAP : int'(size_reg));
		case (op)
			OP_ADD: begin
				if (pos >= 0) begin
					drop_entry(pos);
					push_key(k);
					queue_res('{1'b1, k, 1'b1, 1'b1});
				end else if (held_n < lim) begin
					push_key(k);
					queue_res(RES_PLAIN);
				end else begin
					oldest = held_keys[0];
					drop_entry(0);
					push_key(k);
					queue_res('{1'b1, oldest, 1'b0, 1'b1});
				end
			end
			OP_QUERY: begin
				queue_res('{1'b0, 64'd0, pos >= 0, 1'b1});
			end
			OP_FLUSH: begin
				if (held_n == 0)
					queue_res(RES_PLAIN);
				for (int i = 0; i < held_n; i++)
					queue_res('{1'b1, held_keys[i], 1'b0, i == held_n - 1});
				held_n = 0;
			end
			default: begin
				queue_res(RES_PLAIN);
			end
		endcase
	endfunction

	task automatic send_item(input op_t op, input logic [KEY_W-1:0] k, input logic chk,
			input res_t want);
		start <= 1'b1;
		kind <= op;
		key <= k;
		do @(posedge clk); while (busy);
		predict_item(op, k);
		if (chk)
			pending_res.insert(pending_res.size(), want);
		else
			foreach (next_res[i]) pending_res.insert(pending_res.size(), next_res[i]);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_size(input logic [CFG_W-1:0] v);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		size_reg = v;
		cfg_we <= 1'b0;
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(9))
			0: return 64'd0;
			1: return KEY_ONES;
			2, 3, 4, 5, 6: return key_pool[$urandom_range(POOL_N - 1)];
			default: return {$urandom, $urandom};
		endcase
	endfunction

	always @(posedge clk) begin
		res_t want;
		if (arst_n && done) begin
			if (pending_res.size() == 0) begin
				$error("unexpected result transaction: unload_key %h", unload_key);
				err_cnt++;
			end else begin
				want = pending_res[0];
				pending_res.delete(0);
				if (has_unload !== want.has_unload) begin
					$error("has_unload: expected %0d, got %0d", want.has_unload, has_unload);
					err_cnt++;
				end
				if (unload_key !== want.unload_key) begin
					$error("unload_key: expected %h, got %h", want.unload_key, unload_key);
					err_cnt++;
				end
				if (present !== want.present) begin
					$error("present: expected %0d, got %0d", want.present, present);
					err_cnt++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, last);
					err_cnt++;
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		op_t              op;
		int               r;
		int               gap;
		logic [CFG_W-1:0] sz;
		arst_n = 1'b0;
		start = 1'b0;
		kind = '0;
		key = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		held_n = 0;
		size_reg = CACHE_SIZE_RST;
		foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].cfg)
				write_size(dir_rows[i].size);
			else
				send_item(dir_rows[i].op, dir_rows[i].key, dir_rows[i].chk, dir_rows[i].want);
		end

		for (int p = 0; p < N_PHASE; p++) begin
			sz = (p == N_PHASE - 1) ? CFG_W'($urandom_range(63)) : phase_size[p];
			write_size(sz);
			for (int n = 0; n < phase_items[p]; n++) begin
				r = $urandom_range(99);
				if (r < flush_pct[p])
					op = OP_FLUSH;
				else if (r < flush_pct[p] + 2)
					op = OP_NOP;
				else if (r < 65)
					op = OP_ADD;
				else
					op = OP_QUERY;
				send_item(op, pick_key(), 1'b0, RES_PLAIN);
				if (p == 1 && n == 15)
					drain_results();
				gap = 0;
				while ($urandom_range(99) < idle_pct[p]) gap++;
				if (gap > 0) begin
					start <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end

		drain_results();
		if (err_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
